// File: rtl/vdrh_pkg.sv
package vdrh_pkg;

    // Configuration register file
    localparam int          BINS_W       = 7;
    localparam logic [BINS_W-1:0] BINS_RESET = 7'd64;
    localparam int          PADDR_W      = 3;
    localparam logic        REG_BINS_IDX = 1'b0;   // word index of bins_in_use

    // Result field widths
    localparam int          ROW_OUT_W    = 10;
    localparam int          BIN_OUT_W    = 6;
    localparam int          CNT_OUT_W    = 11;
    localparam int          DISP_W       = 8;

    // Controls broadcast to every counting cell
    typedef struct packed {
        logic pix_valid;   // pixel accepted this cycle
        logic row_end;     // accepted pixel closes its row: snapshot and clear
        logic shift;       // result taken: dump chain moves one cell toward the head
    } cell_ctrl_t;

endpackage

// File: rtl/vdrh_cell.sv
module vdrh_cell #(
    parameter int BIN            = 0,
    parameter int MAX_BINS       = 64,
    parameter int MAX_ROW_PIXELS = 1024
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  vdrh_pkg::cell_ctrl_t                      ctrl,
    input  logic [vdrh_pkg::DISP_W-1:0]               disparity,
    input  logic [$clog2(MAX_BINS+1)-1:0]             bins_eff,
    input  logic [$clog2(MAX_ROW_PIXELS+1)-1:0]       dump_in,
    output logic [$clog2(MAX_ROW_PIXELS+1)-1:0]       dump_out
);

    localparam int CNT_W = $clog2(MAX_ROW_PIXELS + 1);
    localparam int NB_W  = $clog2(MAX_BINS + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] dump_reg;
    logic [CNT_W-1:0] dump_next;
    logic             hit;

    assign hit = ctrl.pix_valid
              && ({1'b0, disparity} == (vdrh_pkg::DISP_W + 1)'(BIN))
              && (NB_W'(BIN) < bins_eff);

    // saturating count, includes the pixel of this cycle
    assign cnt_inc = (hit && (cnt_reg != CNT_W'(MAX_ROW_PIXELS))) ? cnt_reg + 1'b1 : cnt_reg;

    always_comb begin
        cnt_next  = cnt_inc;
        dump_next = dump_reg;
        if (ctrl.row_end) begin
            cnt_next  = '0;
            dump_next = cnt_inc;
        end else if (ctrl.shift) begin
            dump_next = dump_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dump_reg <= dump_next;
    end

    assign dump_out = dump_reg;

endmodule

// File: rtl/v_disparity_row_histogram.sv
// V-disparity row histogram. Takes one disparity pixel per cycle in raster order
// and counts, per row, the pixels at each disparity 0..bins_in_use-1 (larger values
// are ignored, counts saturate at MAX_ROW_PIXELS). A row of MAX_BINS cells holds the
// live counters; on the row-end pixel every cell copies its count into a second
// register and clears, so the next row is counted while the old one drains. The
// copies shift toward cell 0 one place per taken result, giving one result per cycle
// while m_ready is high (row, bin, count, last-bin) in ascending bin order. Ordinary
// pixels are always taken at one per cycle; a row-end pixel waits until the previous
// row's results are all taken. Reset clears all counters at once. bins_in_use
// (APB address 0, reset 64) is clamped into 1..MAX_BINS.
module v_disparity_row_histogram #(
    parameter int MAX_BINS       = 64,
    parameter int MAX_ROW_PIXELS = 1024,
    parameter int MAX_ROWS       = 1024
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // APB configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [vdrh_pkg::PADDR_W-1:0]          paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    // pixel input
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [vdrh_pkg::DISP_W-1:0]           s_disparity,
    input  logic                                  s_end_of_row,
    // histogram results
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [vdrh_pkg::ROW_OUT_W-1:0]        m_row_number,
    output logic [vdrh_pkg::BIN_OUT_W-1:0]        m_bin_index,
    output logic [vdrh_pkg::CNT_OUT_W-1:0]        m_pixel_count,
    output logic                                  m_last_bin
);

    localparam int CNT_W = $clog2(MAX_ROW_PIXELS + 1);
    localparam int NB_W  = $clog2(MAX_BINS + 1);
    localparam int IDX_W = $clog2(MAX_BINS);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int CMP_W = (NB_W > vdrh_pkg::BINS_W) ? NB_W : vdrh_pkg::BINS_W;

    logic [vdrh_pkg::BINS_W-1:0] bins_reg;
    logic [NB_W-1:0]             bins_eff;
    logic [NB_W-1:0]             nb_reg;
    logic [IDX_W-1:0]            idx_reg;
    logic [ROW_W-1:0]            row_reg;
    logic [ROW_W-1:0]            row_out_reg;
    logic                        busy_reg;
    logic                        pix_acc;
    logic                        row_end;
    logic                        res_acc;
    logic                        last_now;
    vdrh_pkg::cell_ctrl_t        ctrl;
    logic [CNT_W-1:0]            dump_w [MAX_BINS];
    logic                        cfg_wr;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == vdrh_pkg::REG_BINS_IDX);
    assign prdata = (paddr[2] == vdrh_pkg::REG_BINS_IDX) ? 32'(bins_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bins_reg <= vdrh_pkg::BINS_RESET;
        end else if (cfg_wr) begin
            bins_reg <= pwdata[vdrh_pkg::BINS_W-1:0];
        end
    end

    always_comb begin
        if (bins_reg == '0) begin
            bins_eff = NB_W'(1);
        end else if (CMP_W'(bins_reg) > CMP_W'(MAX_BINS)) begin
            bins_eff = NB_W'(MAX_BINS);
        end else begin
            bins_eff = NB_W'(bins_reg);
        end
    end

    // ---------------- handshake control ----------------
    assign s_ready  = !busy_reg || !s_end_of_row;
    assign pix_acc  = s_valid && s_ready;
    assign row_end  = pix_acc && s_end_of_row;
    assign res_acc  = busy_reg && m_ready;
    assign last_now = (NB_W'(idx_reg) == nb_reg - 1'b1);

    assign ctrl.pix_valid = pix_acc;
    assign ctrl.row_end   = row_end;
    assign ctrl.shift     = res_acc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            row_reg  <= '0;
        end else begin
            if (row_end) begin
                busy_reg <= 1'b1;
                row_reg  <= (row_reg == ROW_W'(MAX_ROWS - 1)) ? '0 : row_reg + 1'b1;
            end else if (res_acc && last_now) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (row_end) begin
            nb_reg      <= bins_eff;
            idx_reg     <= '0;
            row_out_reg <= row_reg;
        end else if (res_acc) begin
            idx_reg     <= idx_reg + 1'b1;
        end
    end

    // ---------------- cell chain ----------------
    for (genvar i = 0; i < MAX_BINS; i++) begin : g_cell
        logic [CNT_W-1:0] nbr;
        if (i == MAX_BINS - 1) begin : g_tail
            assign nbr = '0;
        end else begin : g_mid
            assign nbr = dump_w[i+1];
        end
        vdrh_cell #(
            .BIN            (i),
            .MAX_BINS       (MAX_BINS),
            .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .disparity (s_disparity),
            .bins_eff  (bins_eff),
            .dump_in   (nbr),
            .dump_out  (dump_w[i])
        );
    end

    // ---------------- results ----------------
    assign m_valid       = busy_reg;
    assign m_row_number  = vdrh_pkg::ROW_OUT_W'(row_out_reg);
    assign m_bin_index   = vdrh_pkg::BIN_OUT_W'(idx_reg);
    assign m_pixel_count = vdrh_pkg::CNT_OUT_W'(dump_w[0]);
    assign m_last_bin    = last_now;

endmodule

// File: rtl/vdrh_checker.sv
module vdrh_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [vdrh_pkg::ROW_OUT_W-1:0]     m_row_number,
    input logic [vdrh_pkg::BIN_OUT_W-1:0]     m_bin_index,
    input logic                               m_last_bin
);

    // a pending result is never withdrawn
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result withdrawn before transaction");

    // bins of one row come out back to back in ascending order
    a_bin_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_bin |=>
            m_valid && (m_bin_index == vdrh_pkg::BIN_OUT_W'($past(m_bin_index) + 1'b1))
            && (m_row_number == $past(m_row_number)))
        else $error("bin sequence broken within a row");

    // every histogram starts at bin zero
    a_first_bin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> (m_bin_index == '0))
        else $error("histogram does not start at bin zero");

    // input stalls only while a row is draining
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no results pending");

endmodule

bind v_disparity_row_histogram vdrh_checker u_vdrh_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_row_number (m_row_number),
    .m_bin_index  (m_bin_index),
    .m_last_bin   (m_last_bin)
);
